### rtl/core/gregorian_date_difference_top_assert.svh
// Assertion macros shared by the checkers of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GREGORIAN_DATE_DIFFERENCE_TOP_ASSERT_SVH
`define GREGORIAN_DATE_DIFFERENCE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define GDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define GDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define GDD_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gdd_pkg.sv
`timescale 1ns / 1ps

package gdd_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int SERIAL_W = 22;
  localparam int DIFF_W   = 23;
  localparam int QUOT_W   = 8;
  localparam int PROD_W   = 27;

  localparam logic [YEAR_W-1:0]   YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0]  MONTH_MAX = 4'd12;
  localparam logic [MONTH_W-1:0]  FEBRUARY  = 4'd2;
  localparam logic [DAY_W-1:0]    LEAP_FEB  = 5'd29;
  localparam logic [PROD_W-1:0]   RECIP_100 = 27'd5243;
  localparam int                  RECIP_SH  = 19;
  localparam logic [SERIAL_W:0]   YEAR_DAYS = 23'd365;
  localparam logic [6:0]          HUNDRED   = 7'd100;

  typedef struct packed {
    logic [YEAR_W-1:0]  first_year;
    logic [MONTH_W-1:0] first_month;
    logic [DAY_W-1:0]   first_day;
    logic [YEAR_W-1:0]  second_year;
    logic [MONTH_W-1:0] second_month;
    logic [DAY_W-1:0]   second_day;
    logic               include_end;
  } gdd_in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] day_difference;
    logic                     date_invalid;
  } gdd_out_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] n;
    unique case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

### rtl/core/gdd_serial.sv
`timescale 1ns / 1ps

module gdd_serial (
  input  logic                            clk,
  input  logic                            en,
  input  logic [gdd_pkg::YEAR_W-1:0]      year,
  input  logic [gdd_pkg::MONTH_W-1:0]     month,
  input  logic [gdd_pkg::DAY_W-1:0]       day,
  output logic [gdd_pkg::SERIAL_W-1:0]    serial,
  output logic                            ok
);

  logic [gdd_pkg::PROD_W-1:0]   prod_y;
  logic [gdd_pkg::PROD_W-1:0]   prod_p;
  logic [gdd_pkg::YEAR_W-1:0]   p_next;

  logic [gdd_pkg::YEAR_W-1:0]   y1;
  logic [gdd_pkg::YEAR_W-1:0]   p1;
  logic [gdd_pkg::MONTH_W-1:0]  m1;
  logic [gdd_pkg::DAY_W-1:0]    d1;
  logic [gdd_pkg::QUOT_W-1:0]   qy1;
  logic [gdd_pkg::QUOT_W-1:0]   qp1;

  logic [gdd_pkg::YEAR_W:0]     cent;
  logic                         div100;
  logic                         leap;
  logic [gdd_pkg::DAY_W-1:0]    len;
  logic                         ok_next;
  logic [gdd_pkg::SERIAL_W:0]   years_days;
  logic [gdd_pkg::SERIAL_W-1:0] base_next;
  logic [8:0]                   extra_next;

  logic [gdd_pkg::SERIAL_W-1:0] base2;
  logic [8:0]                   extra2;
  logic                         ok2;

  assign p_next = year - 14'd1;
  assign prod_y = gdd_pkg::PROD_W'(year) * gdd_pkg::RECIP_100;
  assign prod_p = gdd_pkg::PROD_W'(p_next) * gdd_pkg::RECIP_100;

  always_ff @(posedge clk) begin
    if (en) begin
      y1  <= year;
      p1  <= p_next;
      m1  <= month;
      d1  <= day;
      qy1 <= prod_y[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SH];
      qp1 <= prod_p[gdd_pkg::PROD_W-1:gdd_pkg::RECIP_SH];
    end
  end

  always_comb begin
    cent   = (gdd_pkg::YEAR_W + 1)'(qy1) * (gdd_pkg::YEAR_W + 1)'(gdd_pkg::HUNDRED);
    div100 = (cent == {1'b0, y1});
    leap   = ((y1[1:0] == 2'd0) && !div100) || (div100 && (qy1[1:0] == 2'd0));
    len    = ((m1 == gdd_pkg::FEBRUARY) && leap) ? gdd_pkg::LEAP_FEB : gdd_pkg::month_len(m1);
    ok_next = (y1 != '0) && (y1 <= gdd_pkg::YEAR_MAX) && (m1 != '0) &&
              (m1 <= gdd_pkg::MONTH_MAX) && (d1 != '0) && (d1 <= len);
    years_days = (gdd_pkg::SERIAL_W + 1)'(p1) * gdd_pkg::YEAR_DAYS;
    base_next  = gdd_pkg::SERIAL_W'(years_days + (gdd_pkg::SERIAL_W + 1)'(p1 >> 2)
                 - (gdd_pkg::SERIAL_W + 1)'(qp1) + (gdd_pkg::SERIAL_W + 1)'(qp1 >> 2));
    extra_next = gdd_pkg::days_before(m1) + 9'(d1) +
                 9'((m1 > gdd_pkg::FEBRUARY) && leap);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base2  <= base_next;
      extra2 <= extra_next;
      ok2    <= ok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      serial <= base2 + gdd_pkg::SERIAL_W'(extra2);
      ok     <= ok2;
    end
  end

endmodule

### rtl/core/gregorian_date_difference_top.sv
`timescale 1ns / 1ps
// Gregorian date difference in days.
// The dates channel carries one beat per request: two calendar dates and the
// include_end flag. The diff channel carries one beat per request: the signed
// day count from the first date to the second, and date_invalid, which is set
// with a zero count when either date is not a real calendar date.
// Each date is turned into a serial day number by its own pipeline, and the
// two numbers are subtracted in the last stage.
// When the receiver does not stall, diff_valid rises once the accepted dates beat
// has passed through every stage register. One request is accepted every cycle
// while no result waits or diff_ready is high; the four-stage pipeline advances as a whole.
// When the receiver holds diff_ready low while a result waits, every stage
// freezes and dates_ready falls; nothing is lost or repeated.
// Synchronous reset empties the pipeline; results in flight are dropped.
module gregorian_date_difference_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              dates_valid,
  output logic              dates_ready,
  input  gdd_pkg::gdd_in_t  dates,
  output logic              diff_valid,
  input  logic              diff_ready,
  output gdd_pkg::gdd_out_t diff
);

  logic                         en;
  logic                         v1;
  logic                         v2;
  logic                         v3;
  logic                         inc1;
  logic                         inc2;
  logic                         inc3;
  logic [gdd_pkg::SERIAL_W-1:0] serial_a;
  logic [gdd_pkg::SERIAL_W-1:0] serial_b;
  logic                         ok_a;
  logic                         ok_b;
  logic [gdd_pkg::DIFF_W-1:0]   raw;
  gdd_pkg::gdd_out_t            diff_next;

  assign en          = !diff_valid || diff_ready;
  assign dates_ready = en;

  gdd_serial u_first (
    .clk    (clk),
    .en     (en),
    .year   (dates.first_year),
    .month  (dates.first_month),
    .day    (dates.first_day),
    .serial (serial_a),
    .ok     (ok_a)
  );

  gdd_serial u_second (
    .clk    (clk),
    .en     (en),
    .year   (dates.second_year),
    .month  (dates.second_month),
    .day    (dates.second_day),
    .serial (serial_b),
    .ok     (ok_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      diff_valid <= 1'b0;
    end else if (en) begin
      v1         <= dates_valid;
      v2         <= v1;
      v3         <= v2;
      diff_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inc1 <= dates.include_end;
      inc2 <= inc1;
      inc3 <= inc2;
    end
  end

  always_comb begin
    raw = {1'b0, serial_b} - {1'b0, serial_a};
    diff_next = '0;
    if (!(ok_a && ok_b)) begin
      diff_next.date_invalid = 1'b1;
    end else if (inc3 && raw[gdd_pkg::DIFF_W-1]) begin
      diff_next.day_difference = $signed(raw - 23'd1);
    end else if (inc3) begin
      diff_next.day_difference = $signed(raw + 23'd1);
    end else begin
      diff_next.day_difference = $signed(raw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_next;
    end
  end

endmodule

### rtl/core/gdd_checker.sv
`timescale 1ns / 1ps
`include "gregorian_date_difference_top_assert.svh"

module gdd_checker (
  input logic              clk,
  input logic              rst,
  input logic              dates_ready,
  input logic              diff_valid,
  input logic              diff_ready,
  input gdd_pkg::gdd_out_t diff
);

  logic signed [gdd_pkg::DIFF_W-1:0] count;
  logic                              shown_bad;
  logic                              shown_good;
  logic                              in_range;

  assign count      = diff.day_difference;
  assign shown_bad  = diff_valid && diff.date_invalid;
  assign shown_good = diff_valid && !diff.date_invalid;
  assign in_range   = (count <= 23'sd3652060) && (count >= -23'sd3652060);

  `GDD_ASSERT_NEXT_ALWAYS(a_reset_empties, rst, !diff_valid, "result shown after reset")
  `GDD_ASSERT_NOW(a_ready_when_empty, !diff_valid, dates_ready, "input stalled while empty")
  `GDD_ASSERT_NOW(a_invalid_zero, shown_bad, count == '0, "invalid date with nonzero count")
  `GDD_ASSERT_NOW(a_range, shown_good, in_range, "day count out of range")
  `GDD_ASSERT_NEXT(a_hold, diff_valid && !diff_ready, diff_valid && $stable(diff), "stall changed")

endmodule

bind gregorian_date_difference_top gdd_checker u_gdd_checker (
  .clk         (clk),
  .rst         (rst),
  .dates_ready (dates_ready),
  .diff_valid  (diff_valid),
  .diff_ready  (diff_ready),
  .diff        (diff)
);

### sim/tb_gregorian_date_difference_top.sv
`timescale 1ns / 1ps

module tb_gregorian_date_difference_top;

  localparam int CLK_HALF       = 6;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int RANDOM_PER_RUN = 132;
  localparam int REPORT_MAX     = 10;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              dates_valid = 1'b0;
  logic              dates_ready;
  gdd_pkg::gdd_in_t  dates = '0;
  logic              diff_valid;
  logic              diff_ready = 1'b0;
  gdd_pkg::gdd_out_t diff;

  gdd_pkg::gdd_out_t pending_diffs[$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       pairs_sent = 0;
  int       invalid_sent = 0;
  int       diffs_checked = 0;
  int       mismatches = 0;
  int       orphan_diffs = 0;

  gregorian_date_difference_top dut (
    .clk         (clk),
    .rst         (rst),
    .dates_valid (dates_valid),
    .dates_ready (dates_ready),
    .dates       (dates),
    .diff_valid  (diff_valid),
    .diff_ready  (diff_ready),
    .diff        (diff)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    int n;
    case (m)
      2:           n = is_leap(y) ? 29 : 28;
      4, 6, 9, 11: n = 30;
      default:     n = 31;
    endcase
    return n;
  endfunction

  function automatic bit real_date(int y, int m, int d);
    if (y < 1 || y > int'(gdd_pkg::YEAR_MAX) || m < 1 || m > int'(gdd_pkg::MONTH_MAX) ||
        d < 1) begin
      return 1'b0;
    end
    return d <= month_days(y, m);
  endfunction

  // Days since the start of the calendar; January 1 of year 1 is day 1.
  function automatic int day_number(int y, int m, int d);
    int p;
    int n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400 + d;
    for (int k = 1; k < m; k++) begin
      n += month_days(y, k);
    end
    return n;
  endfunction

  function automatic gdd_pkg::gdd_out_t predict_day_difference(gdd_pkg::gdd_in_t a);
    gdd_pkg::gdd_out_t r;
    int                span;
    r = '0;
    if (!real_date(a.first_year, a.first_month, a.first_day) ||
        !real_date(a.second_year, a.second_month, a.second_day)) begin
      r.date_invalid = 1'b1;
      return r;
    end
    span = day_number(a.second_year, a.second_month, a.second_day) -
           day_number(a.first_year, a.first_month, a.first_day);
    if (a.include_end) begin
      span = (span < 0) ? span - 1 : span + 1;
    end
    r.day_difference = gdd_pkg::DIFF_W'(span);
    return r;
  endfunction

  function automatic gdd_pkg::gdd_in_t date_pair(int y1, int m1, int d1, int y2, int m2,
                                                 int d2, bit inc);
    gdd_pkg::gdd_in_t a;
    a.first_year   = gdd_pkg::YEAR_W'(y1);
    a.first_month  = gdd_pkg::MONTH_W'(m1);
    a.first_day    = gdd_pkg::DAY_W'(d1);
    a.second_year  = gdd_pkg::YEAR_W'(y2);
    a.second_month = gdd_pkg::MONTH_W'(m2);
    a.second_day   = gdd_pkg::DAY_W'(d2);
    a.include_end  = inc;
    return a;
  endfunction

  function automatic int random_year_near(int y);
    int v;
    v = y + $urandom_range(8) - 4;
    if (v < 1) v = 1;
    if (v > int'(gdd_pkg::YEAR_MAX)) v = int'(gdd_pkg::YEAR_MAX);
    return v;
  endfunction

  function automatic gdd_pkg::gdd_in_t random_date_pair();
    gdd_pkg::gdd_in_t a;
    int               y1, m1, y2, m2, pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      a = gdd_pkg::gdd_in_t'({$urandom, $urandom});
      return a;
    end
    y1 = $urandom_range(1, int'(gdd_pkg::YEAR_MAX));
    y2 = ($urandom_range(1) == 1) ? random_year_near(y1) :
         $urandom_range(1, int'(gdd_pkg::YEAR_MAX));
    if ($urandom_range(9) == 0) begin
      y1 = 400 * $urandom_range(1, 24) + 100 * $urandom_range(3);
      y2 = y1;
    end
    m1 = $urandom_range(1, 12);
    m2 = $urandom_range(1, 12);
    a = date_pair(y1, m1, $urandom_range(1, month_days(y1, m1)),
                  y2, m2, $urandom_range(1, month_days(y2, m2)), 1'($urandom_range(1)));
    if (pick < 16) begin
      case ($urandom_range(3))
        0: a.second_day   = gdd_pkg::DAY_W'(month_days(y2, m2) + 1);
        1: a.first_month  = $urandom_range(1) ? 4'd0 : gdd_pkg::MONTH_W'($urandom_range(13, 15));
        2: a.first_day    = '0;
        default: a.second_year = $urandom_range(1) ? '0 :
                                 gdd_pkg::YEAR_W'($urandom_range(10000, 16383));
      endcase
    end
    return a;
  endfunction

  task automatic send_dates(gdd_pkg::gdd_in_t a);
    gdd_pkg::gdd_out_t want;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      dates_valid <= 1'b0;
      @(posedge clk);
    end
    dates_valid <= 1'b1;
    dates       <= a;
    @(posedge clk);
    while (!dates_ready) @(posedge clk);
    want = predict_day_difference(a);
    pending_diffs.push_back(want);
    pairs_sent++;
    if (want.date_invalid) invalid_sent++;
  endtask

  always @(posedge clk) begin
    diff_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    gdd_pkg::gdd_out_t want;
    if (!rst && diff_valid && diff_ready) begin
      if (pending_diffs.size() == 0) begin
        orphan_diffs++;
        if (mismatches + orphan_diffs <= REPORT_MAX) begin
          $display("unexpected diff beat: day_difference=%0d date_invalid=%0b",
                   diff.day_difference, diff.date_invalid);
        end
      end else begin
        want = pending_diffs.pop_front();
        diffs_checked++;
        if (diff.day_difference !== want.day_difference ||
            diff.date_invalid !== want.date_invalid) begin
          mismatches++;
          if (mismatches + orphan_diffs <= REPORT_MAX) begin
            $display("diff beat %0d: expected day_difference=%0d date_invalid=%0b, got %0d %0b",
                     diffs_checked, want.day_difference, want.date_invalid,
                     diff.day_difference, diff.date_invalid);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (dates_valid && dates_ready) || (diff_valid && diff_ready)) begin
        quiet = 0;
      end else if (pending_diffs.size() != 0 || dates_valid) begin
        quiet++;
      end
    end
    $display("Timed out with %0d results outstanding.", pending_diffs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic test_calendar_extremes();
    send_dates(date_pair(1, 1, 1, 9999, 12, 31, 1'b0));
    send_dates(date_pair(1, 1, 1, 9999, 12, 31, 1'b1));
    send_dates(date_pair(9999, 12, 31, 1, 1, 1, 1'b0));
    send_dates(date_pair(9999, 12, 31, 1, 1, 1, 1'b1));
    send_dates(date_pair(0, 6, 15, 2020, 6, 15, 1'b0));
    send_dates(date_pair(2020, 6, 15, 10000, 6, 15, 1'b1));
    send_dates(date_pair(16383, 15, 31, 16383, 15, 31, 1'b1));
    send_dates(date_pair(2020, 0, 10, 2020, 1, 10, 1'b0));
    send_dates(date_pair(2020, 1, 10, 2020, 13, 10, 1'b0));
    send_dates(date_pair(2020, 1, 0, 2020, 4, 31, 1'b0));
    send_dates(date_pair(2020, 12, 31, 2021, 1, 1, 1'b0));
  endtask

  task automatic test_leap_rule();
    send_dates(date_pair(2000, 2, 29, 2000, 3, 1, 1'b0));
    send_dates(date_pair(1900, 2, 29, 1900, 3, 1, 1'b0));
    send_dates(date_pair(1900, 2, 28, 1900, 3, 1, 1'b0));
    send_dates(date_pair(2000, 2, 28, 2000, 3, 1, 1'b0));
    send_dates(date_pair(2004, 2, 29, 2001, 2, 29, 1'b0));
    send_dates(date_pair(2100, 3, 1, 2400, 2, 29, 1'b1));
    send_dates(date_pair(1996, 12, 31, 1997, 1, 1, 1'b1));
  endtask

  task automatic test_equal_and_reversed();
    send_dates(date_pair(1970, 5, 17, 1970, 5, 17, 1'b0));
    send_dates(date_pair(1970, 5, 17, 1970, 5, 17, 1'b1));
    send_dates(date_pair(1970, 5, 18, 1970, 5, 17, 1'b1));
    send_dates(date_pair(2024, 3, 1, 2023, 3, 1, 1'b1));
  endtask

  task automatic test_random_pairs(int idle, int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (RANDOM_PER_RUN) send_dates(random_date_pair());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_calendar_extremes();
    test_leap_rule();
    test_equal_and_reversed();
    test_random_pairs(0, 0);
    test_random_pairs(56, 0);
    test_random_pairs(0, 56);
    test_random_pairs(35, 35);
    dates_valid <= 1'b0;
    while (pending_diffs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d date pairs (%0d with an invalid date), checked %0d results.",
             pairs_sent, invalid_sent, diffs_checked);
    $display("Covered calendar extremes, leap years, equal dates and four stall mixes.");
    if (mismatches == 0 && orphan_diffs == 0 && pending_diffs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d unexpected beats.", mismatches, orphan_diffs);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
